FILE: hw/rtl/dte_pkg.sv
// shared types and constants of the dependency transition engine
package dte_pkg;

  localparam int MAX_WORDS_DEF = 255;
  localparam int LABEL_COUNT   = 64;

  typedef enum logic [2:0] {
    OP_START      = 3'd0,
    OP_SHIFT      = 3'd1,
    OP_LEFT_ARC   = 3'd2,
    OP_RIGHT_ARC  = 3'd3,
    OP_SWAP       = 3'd4,
    OP_LEFT_ARC2  = 3'd5,
    OP_RIGHT_ARC2 = 3'd6
  } dte_op_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_PUSH = 3'd1,
    CELL_POP1 = 3'd2,
    CELL_POP2 = 3'd3,
    CELL_LOAD = 3'd4
  } cell_op_t;

  // cells with an index below keep hold, the rest follow op
  typedef struct packed {
    cell_op_t   op;
    logic [1:0] keep;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] arc_label;
    logic [7:0] word_count;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       arc_made;
    logic [7:0] child_node;
    logic [7:0] parent_node;
    logic [5:0] label_out;
    logic [8:0] stack_depth;
    logic [8:0] pending_words;
  } out_word_t;

endpackage

FILE: hw/rtl/dte_cell.sv
// one storage cell of the stack or buffer row
module dte_cell import dte_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic [7:0] ld_val,
  input  logic [7:0] up_val,
  input  logic [7:0] dn1_val,
  input  logic [7:0] dn2_val,
  output logic [7:0] val_r
);

  // only the three top cells can be told to hold by keep
  localparam logic [1:0] IDX2 = (IDX < 3) ? IDX[1:0] : 2'd3;

  logic [7:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (IDX2 >= cmd.keep) begin
      case (cmd.op)
        CELL_HOLD: val_nxt = val_r;
        CELL_PUSH: val_nxt = up_val;
        CELL_POP1: val_nxt = dn1_val;
        CELL_POP2: val_nxt = dn2_val;
        CELL_LOAD: val_nxt = ld_val;
        default:   val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: hw/rtl/dte_ctrl.sv
// transition decode: applicability checks, row commands, counts and result word
module dte_ctrl import dte_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int CW        = $clog2(MAX_WORDS + 2)
) (
  input  in_word_t        item,
  input  logic [7:0]      s0,
  input  logic [7:0]      s1,
  input  logic [7:0]      s2,
  input  logic [CW-1:0]   stack_cnt,
  input  logic [CW-1:0]   buf_cnt,
  output cell_cmd_t       stack_cmd,
  output cell_cmd_t       buf_cmd,
  output logic [CW-1:0]   stack_cnt_nxt,
  output logic [CW-1:0]   buf_cnt_nxt,
  output out_word_t       result
);

  localparam int DEPTH = MAX_WORDS + 1;
  localparam cell_cmd_t HOLD_CMD = '{op: CELL_HOLD, keep: 2'd0};

  logic       label_ok;
  logic       stk_room;
  logic       buf_room;
  logic       has2;
  logic       has3;
  logic       ok;
  logic       arc;
  logic [7:0] child;
  logic [7:0] parent;
  logic [7:0] n_clamp;

  always_comb begin
    label_ok = int'(item.arc_label) < LABEL_COUNT;
    stk_room = stack_cnt < CW'(DEPTH);
    buf_room = buf_cnt < CW'(DEPTH);
    has2     = stack_cnt >= CW'(2);
    has3     = stack_cnt >= CW'(3);
    n_clamp  = (int'(item.word_count) > MAX_WORDS) ? 8'(MAX_WORDS) : item.word_count;

    ok            = 1'b0;
    arc           = 1'b0;
    child         = 8'd0;
    parent        = 8'd0;
    stack_cmd     = HOLD_CMD;
    buf_cmd       = HOLD_CMD;
    stack_cnt_nxt = stack_cnt;
    buf_cnt_nxt   = buf_cnt;

    case (item.op)
      OP_START: begin
        ok            = 1'b1;
        stack_cmd     = '{op: CELL_LOAD, keep: 2'd0};
        buf_cmd       = '{op: CELL_LOAD, keep: 2'd0};
        stack_cnt_nxt = CW'(1);
        buf_cnt_nxt   = CW'(n_clamp);
      end
      OP_SHIFT: begin
        if ((buf_cnt != '0) && stk_room) begin
          ok            = 1'b1;
          stack_cmd     = '{op: CELL_PUSH, keep: 2'd0};
          buf_cmd       = '{op: CELL_POP1, keep: 2'd0};
          stack_cnt_nxt = stack_cnt + CW'(1);
          buf_cnt_nxt   = buf_cnt - CW'(1);
        end
      end
      OP_LEFT_ARC: begin
        if (label_ok && has2 && (s1 != 8'd0)) begin
          ok            = 1'b1;
          arc           = 1'b1;
          parent        = s0;
          child         = s1;
          stack_cmd     = '{op: CELL_POP1, keep: 2'd1};
          stack_cnt_nxt = stack_cnt - CW'(1);
        end
      end
      OP_RIGHT_ARC: begin
        if (label_ok && has2) begin
          ok            = 1'b1;
          arc           = 1'b1;
          child         = s0;
          parent        = s1;
          stack_cmd     = '{op: CELL_POP1, keep: 2'd0};
          stack_cnt_nxt = stack_cnt - CW'(1);
        end
      end
      OP_SWAP: begin
        if (buf_room && has2 && (s1 != 8'd0) && (s1 < s0)) begin
          ok            = 1'b1;
          stack_cmd     = '{op: CELL_POP1, keep: 2'd1};
          buf_cmd       = '{op: CELL_PUSH, keep: 2'd0};
          stack_cnt_nxt = stack_cnt - CW'(1);
          buf_cnt_nxt   = buf_cnt + CW'(1);
        end
      end
      OP_LEFT_ARC2: begin
        if (label_ok && has3 && (s2 != 8'd0)) begin
          ok            = 1'b1;
          arc           = 1'b1;
          parent        = s0;
          child         = s2;
          stack_cmd     = '{op: CELL_POP1, keep: 2'd2};
          stack_cnt_nxt = stack_cnt - CW'(1);
        end
      end
      OP_RIGHT_ARC2: begin
        if (label_ok && buf_room && has3) begin
          ok            = 1'b1;
          arc           = 1'b1;
          child         = s0;
          parent        = s2;
          stack_cmd     = '{op: CELL_POP2, keep: 2'd0};
          buf_cmd       = '{op: CELL_PUSH, keep: 2'd0};
          stack_cnt_nxt = stack_cnt - CW'(2);
          buf_cnt_nxt   = buf_cnt + CW'(1);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    result.accepted      = ok;
    result.arc_made      = arc;
    result.child_node    = child;
    result.parent_node   = parent;
    result.label_out     = arc ? item.arc_label : 6'd0;
    result.stack_depth   = 9'(stack_cnt_nxt);
    result.pending_words = 9'(buf_cnt_nxt);
  end

endmodule

FILE: hw/rtl/dependency_transition_engine.sv
// top level: holding register, transition decode and the stack and buffer cell rows
//
//  channel  | dir | handshake           | word
//  ---------+-----+---------------------+-------------------------------------------
//  in_      | in  | in_valid / in_stall | in_word_t: op, arc_label, word_count
//  out_     | out | out_valid/out_stall | out_word_t: accepted, arc, nodes, counts
//
//  an accepted word is registered in the holding register, then the transition
//  is applied across both cell rows as the result is registered; the path from
//  input accept to result runs through the holding and result registers, and one
//  word per cycle is sustained while the result side keeps up
//  the per-cycle limit is the row shift: each cell picks from itself, a neighbor, the cell two below or its load value
//  reset clears the counts and both handshake flags and holds in_stall high;
//  cell contents stay undefined
//  a stalled result holds the next word in the holding register, then in_stall rises
module dependency_transition_engine import dte_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int DEPTH = MAX_WORDS + 1;
  localparam int CW    = $clog2(MAX_WORDS + 2);
  localparam cell_cmd_t HOLD_CMD = '{op: CELL_HOLD, keep: 2'd0};

  // holding register in front of the decode
  logic      hold_r, hold_nxt;
  in_word_t  item_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r;

  // entry counts of both rows
  logic [CW-1:0] stack_cnt_r, stack_cnt_nxt;
  logic [CW-1:0] buf_cnt_r, buf_cnt_nxt;
  logic [CW-1:0] stack_cnt_calc, buf_cnt_calc;

  logic      in_take;
  logic      exec;
  cell_cmd_t stack_cmd_calc, buf_cmd_calc;
  cell_cmd_t stack_cmd, buf_cmd;
  out_word_t result;

  // cell outputs, index 0 is the stack top and the next buffer word
  logic [7:0] stk_val [DEPTH];
  logic [7:0] buf_val [DEPTH];

  // execute when a word is held and the result register is free or draining
  // no word is taken while reset is held
  assign exec     = hold_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (hold_r && !exec);
  assign in_take  = in_valid && !in_stall;

  assign stack_cmd = exec ? stack_cmd_calc : HOLD_CMD;
  assign buf_cmd   = exec ? buf_cmd_calc : HOLD_CMD;

  dte_ctrl #(
    .MAX_WORDS (MAX_WORDS),
    .CW        (CW)
  ) u_ctrl (
    .item          (item_r),
    .s0            (stk_val[0]),
    .s1            ((DEPTH > 1) ? stk_val[1 % DEPTH] : 8'd0),
    .s2            ((DEPTH > 2) ? stk_val[2 % DEPTH] : 8'd0),
    .stack_cnt     (stack_cnt_r),
    .buf_cnt       (buf_cnt_r),
    .stack_cmd     (stack_cmd_calc),
    .buf_cmd       (buf_cmd_calc),
    .stack_cnt_nxt (stack_cnt_calc),
    .buf_cnt_nxt   (buf_cnt_calc),
    .result        (result)
  );

  // stack row: cell 0 pushes the next buffer word, start leaves the root on top
  // buffer row: cell 0 pushes stack entry s1, start loads words 1..n from the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic [7:0] stk_up, stk_dn1, stk_dn2;
    logic [7:0] buf_up, buf_dn1, buf_dn2;

    assign stk_up  = (i == 0) ? buf_val[0] : stk_val[(i + DEPTH - 1) % DEPTH];
    assign buf_up  = (i == 0) ? ((DEPTH > 1) ? stk_val[1 % DEPTH] : 8'd0)
                              : buf_val[(i + DEPTH - 1) % DEPTH];
    assign stk_dn1 = (i + 1 < DEPTH) ? stk_val[(i + 1) % DEPTH] : 8'd0;
    assign stk_dn2 = (i + 2 < DEPTH) ? stk_val[(i + 2) % DEPTH] : 8'd0;
    assign buf_dn1 = (i + 1 < DEPTH) ? buf_val[(i + 1) % DEPTH] : 8'd0;
    assign buf_dn2 = (i + 2 < DEPTH) ? buf_val[(i + 2) % DEPTH] : 8'd0;

    dte_cell #(.IDX(i)) u_stk (
      .clk     (clk),
      .cmd     (stack_cmd),
      .ld_val  (8'd0),
      .up_val  (stk_up),
      .dn1_val (stk_dn1),
      .dn2_val (stk_dn2),
      .val_r   (stk_val[i])
    );

    dte_cell #(.IDX(i)) u_buf (
      .clk     (clk),
      .cmd     (buf_cmd),
      .ld_val  (8'(i + 1)),
      .up_val  (buf_up),
      .dn1_val (buf_dn1),
      .dn2_val (buf_dn2),
      .val_r   (buf_val[i])
    );
  end

  // control next state
  always_comb begin
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    stack_cnt_nxt = stack_cnt_r;
    buf_cnt_nxt   = buf_cnt_r;
    if (exec) begin
      hold_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      stack_cnt_nxt = stack_cnt_calc;
      buf_cnt_nxt   = buf_cnt_calc;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_take) begin
      hold_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
      stack_cnt_r <= '0;
      buf_cnt_r   <= '0;
    end else begin
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      stack_cnt_r <= stack_cnt_nxt;
      buf_cnt_r   <= buf_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
    if (exec) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/dte_checker.sv
// port-level checks of the dependency transition engine, bound to the top level
module dte_checker import dte_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // an arc only comes from an applied transition
  a_arc_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.arc_made |-> out_data.accepted)
    else $error("arc reported on a rejected transition");

  // arc fields are zero when no arc was made
  a_arc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.arc_made |->
      out_data.child_node == 8'd0 && out_data.parent_node == 8'd0 &&
      out_data.label_out == 6'd0)
    else $error("arc fields set without an arc");

  // a result word is showing once an accepted word has passed the holding and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("no result two cycles after an accepted word");

endmodule

bind dependency_transition_engine dte_checker u_dte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
